[hdl/rtt_pkg.sv]
// ----------------------------------------------------------------------------
// rtt_pkg
// Types and constants shared by the retransmit timeout table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtt_pkg;

    localparam int SERIAL_W = 16;
    localparam int CMD_W    = 16;
    localparam int COUNT_W  = 8;

    localparam logic [COUNT_W-1:0] DEFAULT_MAX = 8'd3;
    localparam logic [COUNT_W-1:0] COUNT_SAT   = 8'd255;

    localparam int RES_CNT_W = 6;
    localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 6'd32;

    localparam logic [2:0] KIND_APPEND  = 3'd0;
    localparam logic [2:0] KIND_START   = 3'd1;
    localparam logic [2:0] KIND_TICK    = 3'd2;
    localparam logic [2:0] KIND_RECEIVE = 3'd3;
    localparam logic [2:0] KIND_STOP    = 3'd4;

    localparam logic [1:0] ACT_TRANSMIT = 2'd0;
    localparam logic [1:0] ACT_NET_ERR  = 2'd1;
    localparam logic [1:0] ACT_DELIVER  = 2'd2;
    localparam logic [1:0] ACT_FULL     = 2'd3;

    localparam logic [2:0] REG_MAX_TIMEOUTS = 3'd0;
    localparam logic [2:0] REG_HEARTBEAT    = 3'd1;
    localparam logic [2:0] REG_NOTIFY       = 3'd2;
    localparam logic [2:0] REG_CMD_MIN      = 3'd3;
    localparam logic [2:0] REG_CMD_MAX      = 3'd4;
    localparam logic [2:0] REG_START_SYM    = 3'd5;
    localparam logic [2:0] REG_END_SYM      = 3'd6;

    typedef struct packed {
        logic                valid;
        logic [SERIAL_W-1:0] serial;
        logic [COUNT_W-1:0]  count;
    } entry_t;

    typedef struct packed {
        logic [7:0]       max_timeouts;
        logic [CMD_W-1:0] heartbeat_code;
        logic [CMD_W-1:0] notify_code;
        logic [CMD_W-1:0] cmd_min;
        logic [CMD_W-1:0] cmd_max;
        logic [7:0]       start_symbol;
        logic [7:0]       end_symbol;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PASS_FIND,
        PASS_WRITE,
        PASS_SEND_ALL,
        PASS_SEND_ZERO,
        PASS_DROP,
        PASS_REMOVE
    } pass_t;

endpackage

`default_nettype wire

[hdl/rtt_in_if.sv]
// ----------------------------------------------------------------------------
// rtt_in_if
// Input channel: one event transaction per valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rtt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] serial_number;
    logic [15:0] cmd_code;
    logic [7:0]  first_byte;
    logic [7:0]  final_byte;
    logic        source_ok;

    modport source (
        output valid, kind, serial_number, cmd_code, first_byte, final_byte, source_ok,
        input  ready
    );

    modport sink (
        input  valid, kind, serial_number, cmd_code, first_byte, final_byte, source_ok,
        output ready
    );
endinterface

`default_nettype wire

[hdl/rtt_out_if.sv]
// ----------------------------------------------------------------------------
// rtt_out_if
// Result channel: one result transaction per valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rtt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] serial_number_out;
    logic [15:0] cmd_code_out;
    logic        last;

    modport source (
        output valid, action, serial_number_out, cmd_code_out, last,
        input  ready
    );

    modport sink (
        input  valid, action, serial_number_out, cmd_code_out, last,
        output ready
    );
endinterface

`default_nettype wire

[hdl/rtt_cell.sv]
// ----------------------------------------------------------------------------
// rtt_cell
// One table slot of the rotating ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtt_cell
    import rtt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   shift,
    input  wire entry_t feed,
    output entry_t      entry
);

    logic                valid_reg;
    logic                valid_next;
    logic [SERIAL_W-1:0] serial_reg;
    logic [SERIAL_W-1:0] serial_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    always_comb
    begin
        valid_next  = shift ? feed.valid  : valid_reg;
        serial_next = shift ? feed.serial : serial_reg;
        count_next  = shift ? feed.count  : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        serial_reg <= serial_next;
        count_reg  <= count_next;
    end

    assign entry = '{valid: valid_reg, serial: serial_reg, count: count_reg};

endmodule

`default_nettype wire

[hdl/rtt_seq.sv]
// ----------------------------------------------------------------------------
// rtt_seq
// Pass sequencer: decodes events, works on the ring head, orders results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtt_seq
    import rtt_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    rtt_in_if.sink      item,
    rtt_out_if.source   result,
    input  wire entry_t head,
    output entry_t      tail,
    output logic        shift
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);

    state_t              state_reg, state_next;
    pass_t               pass_reg, pass_next;
    logic [IDX_W-1:0]    step_reg, step_next;
    logic [SERIAL_W-1:0] serial_reg, serial_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic                hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                any_reg, any_next;
    logic                timer_reg, timer_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;

    logic                pend_valid_reg, pend_valid_next;
    logic [1:0]          pend_action_reg, pend_action_next;
    logic [SERIAL_W-1:0] pend_serial_reg, pend_serial_next;
    logic [CMD_W-1:0]    pend_cmd_reg, pend_cmd_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_action_reg, out_action_next;
    logic [SERIAL_W-1:0] out_serial_reg, out_serial_next;
    logic [CMD_W-1:0]    out_cmd_reg, out_cmd_next;
    logic                out_last_reg, out_last_next;

    logic                out_free;
    logic [COUNT_W-1:0]  lim;
    logic [COUNT_W-1:0]  count_inc;
    logic                emit_req;
    logic [1:0]          emit_action;
    logic                can_emit;
    logic                stall;
    logic                hit_here;
    logic                free_here;
    logic                hit_f;
    logic                free_f;
    logic [IDX_W-1:0]    hit_i;
    logic [IDX_W-1:0]    free_i;
    logic                any_now;
    logic                frame_ok;
    logic                in_range;

    assign item.ready = (state_reg == ST_IDLE);

    assign result.valid             = out_valid_reg;
    assign result.action            = out_action_reg;
    assign result.serial_number_out = out_serial_reg;
    assign result.cmd_code_out      = out_cmd_reg;
    assign result.last              = out_last_reg;

    assign out_free  = !out_valid_reg || result.ready;
    assign lim       = (cfg.max_timeouts == '0) ? DEFAULT_MAX : cfg.max_timeouts;
    assign count_inc = (head.count == COUNT_SAT) ? head.count : head.count + 8'd1;
    assign frame_ok  = (item.first_byte == cfg.start_symbol)
                    && (item.final_byte == cfg.end_symbol) && item.source_ok;
    assign in_range  = (item.cmd_code >= cfg.cmd_min) && (item.cmd_code <= cfg.cmd_max);

    // per-slot work on the ring head
    always_comb
    begin
        tail        = head;
        emit_req    = 1'b0;
        emit_action = ACT_TRANSMIT;
        hit_here    = 1'b0;
        free_here   = 1'b0;
        any_now     = any_reg;
        case (pass_reg)
            PASS_FIND:
            begin
                hit_here  = head.valid && (head.serial == serial_reg) && !hit_found_reg;
                free_here = !head.valid && !free_found_reg;
            end
            PASS_WRITE:
            begin
                if (step_reg == hit_idx_reg)
                begin
                    tail = '{valid: 1'b1, serial: serial_reg, count: '0};
                end
            end
            PASS_SEND_ALL:
            begin
                if (head.valid)
                begin
                    emit_req   = 1'b1;
                    tail.count = count_inc;
                    any_now    = 1'b1;
                end
            end
            PASS_SEND_ZERO:
            begin
                if (head.valid && (head.count == '0))
                begin
                    emit_req   = 1'b1;
                    tail.count = count_inc;
                end
            end
            PASS_DROP:
            begin
                if (head.valid && (head.count == lim))
                begin
                    emit_req    = 1'b1;
                    emit_action = ACT_NET_ERR;
                    tail.valid  = 1'b0;
                end
                else if (head.valid)
                begin
                    any_now = 1'b1;
                end
            end
            PASS_REMOVE:
            begin
                if (head.valid && (head.serial == serial_reg))
                begin
                    tail.valid = 1'b0;
                end
            end
            default:
            begin
                tail = head;
            end
        endcase
    end

    assign hit_f  = hit_found_reg || hit_here;
    assign hit_i  = hit_found_reg ? hit_idx_reg : step_reg;
    assign free_f = free_found_reg || free_here;
    assign free_i = free_found_reg ? free_idx_reg : step_reg;

    assign can_emit = emit_req && (res_cnt_reg != MAX_RESULTS);
    assign stall    = can_emit && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next       = state_reg;
        pass_next        = pass_reg;
        step_next        = step_reg;
        serial_next      = serial_reg;
        cmd_next         = cmd_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        any_next         = any_reg;
        timer_next       = timer_reg;
        res_cnt_next     = res_cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_action_next = pend_action_reg;
        pend_serial_next = pend_serial_reg;
        pend_cmd_next    = pend_cmd_reg;
        out_valid_next   = out_valid_reg;
        out_action_next  = out_action_reg;
        out_serial_next  = out_serial_reg;
        out_cmd_next     = out_cmd_reg;
        out_last_next    = out_last_reg;
        shift            = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    serial_next     = item.serial_number;
                    cmd_next        = item.cmd_code;
                    res_cnt_next    = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    any_next        = 1'b0;
                    step_next       = '0;
                    state_next      = ST_DONE;
                    case (item.kind)
                        KIND_APPEND:
                        begin
                            if ((item.cmd_code == cfg.heartbeat_code)
                                || (item.cmd_code == cfg.notify_code))
                            begin
                                pend_valid_next  = 1'b1;
                                pend_action_next = ACT_TRANSMIT;
                                pend_serial_next = item.serial_number;
                                pend_cmd_next    = item.cmd_code;
                                res_cnt_next     = RES_CNT_W'(1);
                            end
                            else
                            begin
                                pass_next  = PASS_FIND;
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_START:
                        begin
                            pass_next  = timer_reg ? PASS_SEND_ZERO : PASS_SEND_ALL;
                            state_next = ST_SCAN;
                        end
                        KIND_TICK:
                        begin
                            if (timer_reg)
                            begin
                                pass_next  = PASS_DROP;
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_RECEIVE:
                        begin
                            if (frame_ok)
                            begin
                                if (in_range)
                                begin
                                    pend_valid_next  = 1'b1;
                                    pend_action_next = ACT_DELIVER;
                                    pend_serial_next = item.serial_number;
                                    pend_cmd_next    = item.cmd_code;
                                    res_cnt_next     = RES_CNT_W'(1);
                                end
                                pass_next  = PASS_REMOVE;
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_STOP:
                        begin
                            timer_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    shift = 1'b1;
                    step_next = (step_reg == LAST_STEP) ? '0 : step_reg + IDX_W'(1);
                    any_next = any_now;
                    if (hit_here)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = step_reg;
                    end
                    if (free_here)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = step_reg;
                    end
                    if (can_emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_action_next = pend_action_reg;
                            out_serial_next = pend_serial_reg;
                            out_cmd_next    = pend_cmd_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_action_next = emit_action;
                        pend_serial_next = head.serial;
                        pend_cmd_next    = '0;
                        res_cnt_next     = res_cnt_reg + RES_CNT_W'(1);
                    end
                    if (step_reg == LAST_STEP)
                    begin
                        state_next = ST_DONE;
                        case (pass_reg)
                            PASS_FIND:
                            begin
                                if (hit_f)
                                begin
                                    hit_idx_next = hit_i;
                                    pass_next    = PASS_WRITE;
                                    state_next   = ST_SCAN;
                                end
                                else if (free_f)
                                begin
                                    hit_idx_next = free_i;
                                    pass_next    = PASS_WRITE;
                                    state_next   = ST_SCAN;
                                end
                                else
                                begin
                                    pend_valid_next  = 1'b1;
                                    pend_action_next = ACT_FULL;
                                    pend_serial_next = serial_reg;
                                    pend_cmd_next    = cmd_reg;
                                    res_cnt_next     = res_cnt_reg + RES_CNT_W'(1);
                                end
                            end
                            PASS_SEND_ALL:
                            begin
                                timer_next = any_now;
                            end
                            PASS_DROP:
                            begin
                                if (any_now)
                                begin
                                    any_next   = 1'b0;
                                    pass_next  = PASS_SEND_ALL;
                                    state_next = ST_SCAN;
                                end
                                else
                                begin
                                    timer_next = 1'b0;
                                end
                            end
                            default:
                            begin
                                state_next = ST_DONE;
                            end
                        endcase
                    end
                end
            end

            ST_DONE:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = pend_action_reg;
                    out_serial_next = pend_serial_reg;
                    out_cmd_next    = pend_cmd_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pass_reg       <= PASS_FIND;
            step_reg       <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            any_reg        <= 1'b0;
            timer_reg      <= 1'b0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            step_reg       <= step_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            any_reg        <= any_next;
            timer_reg      <= timer_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        serial_reg      <= serial_next;
        cmd_reg         <= cmd_next;
        hit_idx_reg     <= hit_idx_next;
        free_idx_reg    <= free_idx_next;
        pend_action_reg <= pend_action_next;
        pend_serial_reg <= pend_serial_next;
        pend_cmd_reg    <= pend_cmd_next;
        out_action_reg  <= out_action_next;
        out_serial_reg  <= out_serial_next;
        out_cmd_reg     <= out_cmd_next;
        out_last_reg    <= out_last_next;
    end

endmodule

`default_nettype wire

[hdl/retransmit_timeout_table.sv]
// ----------------------------------------------------------------------------
// retransmit_timeout_table
// Table of unacknowledged packets with timeout-driven retransmission.
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_DEPTH cells that rotates one slot per cycle
// past a single sequencer, so table operations are passes over the ring and
// one event transaction is handled at a time. Immediate sends, stop, ignored
// ticks, ignored frames and unused kinds make no pass; start, a received
// frame and an append refused by a full table make one pass; an append that
// is stored and a tick with survivors make two passes (a tick that empties
// the table makes one).
// A result waiting on a stalled result channel holds the ring for as long as
// it waits. At most one result transaction per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module retransmit_timeout_table
    import rtt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    rtt_in_if.sink           item,
    rtt_out_if.source        result,
    input  wire logic        write_enable,
    input  wire logic [2:0]  write_index,
    input  wire logic [15:0] write_data
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    entry_t ring [TABLE_DEPTH];
    entry_t tail;
    logic   shift;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            case (write_index)
                REG_MAX_TIMEOUTS: cfg_next.max_timeouts   = write_data[7:0];
                REG_HEARTBEAT:    cfg_next.heartbeat_code = write_data;
                REG_NOTIFY:       cfg_next.notify_code    = write_data;
                REG_CMD_MIN:      cfg_next.cmd_min        = write_data;
                REG_CMD_MAX:      cfg_next.cmd_max        = write_data;
                REG_START_SYM:    cfg_next.start_symbol   = write_data[7:0];
                REG_END_SYM:      cfg_next.end_symbol     = write_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_timeouts   <= DEFAULT_MAX;
            cfg_reg.heartbeat_code <= '0;
            cfg_reg.notify_code    <= '0;
            cfg_reg.cmd_min        <= '0;
            cfg_reg.cmd_max        <= '1;
            cfg_reg.start_symbol   <= '0;
            cfg_reg.end_symbol     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t feed;
        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign feed = tail;
        end
        else
        begin : g_link
            assign feed = ring[i + 1];
        end

        rtt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .feed  (feed),
            .entry (ring[i])
        );
    end

    rtt_seq #(
        .DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .item   (item),
        .result (result),
        .head   (ring[0]),
        .tail   (tail),
        .shift  (shift)
    );

endmodule

`default_nettype wire

[tb/sv/rtt_table_checker.sv]
// ----------------------------------------------------------------------------
// rtt_table_checker
// Watches the event, result and register ports of the retransmit timeout
// table, keeps its own copy of the table and the timer, and compares every
// result transaction with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtt_table_checker
    import rtt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    rtt_in_if                evt,
    rtt_out_if               res,
    input  wire logic        write_enable,
    input  wire logic [2:0]  write_index,
    input  wire logic [15:0] write_data,
    output int               fail_count,
    output int               pending_count
);

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] serial;
        logic [15:0] cmd;
        logic        last;
    } tx_result_t;

    cfg_t        regs;
    logic        slot_used  [TABLE_DEPTH];
    logic [15:0] slot_sn    [TABLE_DEPTH];
    logic [7:0]  slot_sends [TABLE_DEPTH];
    logic        timer_armed;
    tx_result_t  expected_tx [$];
    tx_result_t  step_tx [$];

    function automatic int occupied();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot_used[i])
                n++;
        return n;
    endfunction

    function automatic void note(input logic [1:0] act, input logic [15:0] sn, cmd);
        tx_result_t r;
        r.action = act;
        r.serial = sn;
        r.cmd    = cmd;
        r.last   = 1'b0;
        if (step_tx.size() < int'(MAX_RESULTS))
            step_tx.push_back(r);
    endfunction

    function automatic void resend(input int i);
        if (slot_sends[i] != COUNT_SAT)
            slot_sends[i]++;
        note(ACT_TRANSMIT, slot_sn[i], 16'h0000);
    endfunction

    function automatic void predict_event(input logic [2:0] kind, input logic [15:0] sn, cmd,
                                          input logic [7:0] fb, lb, input logic src);
        int         i;
        int         hit;
        int         spare;
        logic [7:0] limit;
        step_tx.delete();
        case (kind)
            KIND_APPEND:
            begin
                if (cmd == regs.heartbeat_code || cmd == regs.notify_code)
                    note(ACT_TRANSMIT, sn, cmd);
                else
                begin
                    hit   = -1;
                    spare = -1;
                    for (i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (slot_used[i] && slot_sn[i] == sn && hit < 0)
                            hit = i;
                        if (!slot_used[i] && spare < 0)
                            spare = i;
                    end
                    if (hit < 0)
                        hit = spare;
                    if (hit < 0)
                        note(ACT_FULL, sn, cmd);
                    else
                    begin
                        slot_used[hit]  = 1'b1;
                        slot_sn[hit]    = sn;
                        slot_sends[hit] = 8'd0;
                    end
                end
            end
            KIND_START:
            begin
                if (occupied() > 0)
                begin
                    for (i = 0; i < TABLE_DEPTH; i++)
                        if (slot_used[i] && (!timer_armed || slot_sends[i] == 8'd0))
                            resend(i);
                    timer_armed = 1'b1;
                end
            end
            KIND_TICK:
            begin
                if (timer_armed)
                begin
                    limit = (regs.max_timeouts == 8'd0) ? DEFAULT_MAX : regs.max_timeouts;
                    for (i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (slot_used[i] && slot_sends[i] == limit)
                        begin
                            note(ACT_NET_ERR, slot_sn[i], 16'h0000);
                            slot_used[i] = 1'b0;
                        end
                    end
                    if (occupied() > 0)
                    begin
                        for (i = 0; i < TABLE_DEPTH; i++)
                            if (slot_used[i])
                                resend(i);
                    end
                    else
                        timer_armed = 1'b0;
                end
            end
            KIND_RECEIVE:
            begin
                if (fb == regs.start_symbol && lb == regs.end_symbol && src)
                begin
                    for (i = 0; i < TABLE_DEPTH; i++)
                        if (slot_used[i] && slot_sn[i] == sn)
                            slot_used[i] = 1'b0;
                    if (cmd >= regs.cmd_min && cmd <= regs.cmd_max)
                        note(ACT_DELIVER, sn, cmd);
                end
            end
            KIND_STOP:
                timer_armed = 1'b0;
            default:
                ;
        endcase
        if (step_tx.size() > 0)
            step_tx[step_tx.size() - 1].last = 1'b1;
        foreach (step_tx[j])
            expected_tx.push_back(step_tx[j]);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want, got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tx_result_t want;
        if (!rst_n)
        begin
            regs.max_timeouts   = DEFAULT_MAX;
            regs.heartbeat_code = 16'h0000;
            regs.notify_code    = 16'h0000;
            regs.cmd_min        = 16'h0000;
            regs.cmd_max        = 16'hFFFF;
            regs.start_symbol   = 8'h00;
            regs.end_symbol     = 8'h00;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                slot_used[i]  = 1'b0;
                slot_sn[i]    = 16'h0000;
                slot_sends[i] = 8'd0;
            end
            timer_armed = 1'b0;
            expected_tx.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (write_enable)
            begin
                case (write_index)
                    REG_MAX_TIMEOUTS: regs.max_timeouts   = write_data[7:0];
                    REG_HEARTBEAT:    regs.heartbeat_code = write_data;
                    REG_NOTIFY:       regs.notify_code    = write_data;
                    REG_CMD_MIN:      regs.cmd_min        = write_data;
                    REG_CMD_MAX:      regs.cmd_max        = write_data;
                    REG_START_SYM:    regs.start_symbol   = write_data[7:0];
                    REG_END_SYM:      regs.end_symbol     = write_data[7:0];
                    default:          ;
                endcase
            end

            if (evt.valid && evt.ready)
                predict_event(evt.kind, evt.serial_number, evt.cmd_code,
                              evt.first_byte, evt.final_byte, evt.source_ok);

            if (res.valid && res.ready)
            begin
                if (expected_tx.size() == 0)
                begin
                    $error("unexpected result: action %0h serial %0h cmd %0h last %0h",
                           res.action, res.serial_number_out, res.cmd_code_out, res.last);
                    fail_count++;
                end
                else
                begin
                    want = expected_tx.pop_front();
                    check_field("action", 16'(want.action), 16'(res.action));
                    check_field("serial_number_out", want.serial, res.serial_number_out);
                    check_field("cmd_code_out", want.cmd, res.cmd_code_out);
                    check_field("last", 16'(want.last), 16'(res.last));
                end
            end

            pending_count = expected_tx.size();
        end
    end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives the retransmit timeout table through six register settings: a short
// directed run of the table, timer and frame corner cases, then random packet
// traffic with random idle and stall on both channels, one long result stall
// and one full drain. Checking is done by rtt_table_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rtt_pkg::*;

    localparam int TABLE_DEPTH   = 16;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int RUN_LIMIT     = 1_000_000;
    localparam int PHASE_ITEMS   = 58;
    localparam int POOL_SIZE     = 24;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] serial;
        logic [15:0] cmd;
        logic [7:0]  first_byte;
        logic [7:0]  final_byte;
        logic        source_ok;
    } pkt_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        write_enable;
    logic [2:0]  write_index;
    logic [15:0] write_data;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    bit          hold_request = 1'b0;
    cfg_t        cfg;
    logic [15:0] pool [POOL_SIZE];

    rtt_in_if  evt_if ();
    rtt_out_if res_if ();

    retransmit_timeout_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (evt_if),
        .result       (res_if),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    rtt_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) table_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt           (evt_if),
        .res           (res_if),
        .write_enable  (write_enable),
        .write_index   (write_index),
        .write_data    (write_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (quiet)
            return 0;
        return $urandom_range(12, 0);
    endfunction

    function automatic pkt_item_t make_item(input logic [2:0] kind, input logic [15:0] sn, cmd,
                                            input logic [7:0] fb, lb, input logic src);
        pkt_item_t it;
        it.kind       = kind;
        it.serial     = sn;
        it.cmd        = cmd;
        it.first_byte = fb;
        it.final_byte = lb;
        it.source_ok  = src;
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic offer(input pkt_item_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        evt_if.valid         <= 1'b1;
        evt_if.kind          <= it.kind;
        evt_if.serial_number <= it.serial;
        evt_if.cmd_code      <= it.cmd;
        evt_if.first_byte    <= it.first_byte;
        evt_if.final_byte    <= it.final_byte;
        evt_if.source_ok     <= it.source_ok;
        @(posedge clk);
        while (evt_if.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        evt_if.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= data;
        @(negedge clk);
    endtask

    task automatic program_regs(input cfg_t c);
        write_reg(REG_MAX_TIMEOUTS, {8'h00, c.max_timeouts});
        write_reg(REG_HEARTBEAT, c.heartbeat_code);
        write_reg(REG_NOTIFY, c.notify_code);
        write_reg(REG_CMD_MIN, c.cmd_min);
        write_reg(REG_CMD_MAX, c.cmd_max);
        write_reg(REG_START_SYM, {8'h00, c.start_symbol});
        write_reg(REG_END_SYM, {8'h00, c.end_symbol});
        write_enable <= 1'b0;
        @(negedge clk);
        cfg = c;
    endtask

    task automatic random_traffic(input int n_items, input int hold_at, input int drain_at);
        int          done_items;
        int          pick;
        int          k;
        bit          held;
        bit          drained;
        logic [15:0] sn;
        logic [15:0] code;
        logic [7:0]  fb;
        logic [7:0]  lb;
        logic        src;
        done_items = 0;
        held       = 1'b0;
        drained    = 1'b0;
        for (k = 0; k < POOL_SIZE; k++)
            pool[k] = 16'($urandom);
        while (done_items < n_items)
        begin
            if (!held && hold_at >= 0 && done_items >= hold_at)
            begin
                hold_request = 1'b1;
                held         = 1'b1;
            end
            if (!drained && drain_at >= 0 && done_items >= drain_at)
            begin
                settle();
                drained = 1'b1;
            end
            pick = $urandom_range(99, 0);
            sn   = pool[$urandom_range(POOL_SIZE - 1, 0)];
            fb   = 8'($urandom);
            lb   = 8'($urandom);
            src  = 1'($urandom);
            done_items++;
            if (pick < 3)
            begin
                // burst of fresh serials: overflows the table
                for (k = 0; k <= TABLE_DEPTH; k++)
                    offer(make_item(KIND_APPEND, 16'($urandom), 16'($urandom), fb, lb, src));
                done_items += TABLE_DEPTH;
            end
            else if (pick < 33)
                offer(make_item(KIND_APPEND, sn, 16'($urandom), fb, lb, src));
            else if (pick < 39)
            begin
                code = ($urandom_range(1, 0) != 0) ? cfg.heartbeat_code : cfg.notify_code;
                offer(make_item(KIND_APPEND, sn, code, fb, lb, src));
            end
            else if (pick < 49)
                offer(make_item(KIND_START, sn, 16'($urandom), fb, lb, src));
            else if (pick < 67)
                offer(make_item(KIND_TICK, sn, 16'($urandom), fb, lb, src));
            else if (pick < 83)
            begin
                code = 16'($urandom);
                if (cfg.cmd_min <= cfg.cmd_max && $urandom_range(3, 0) != 0)
                    code = 16'($urandom_range(int'(cfg.cmd_max), int'(cfg.cmd_min)));
                offer(make_item(KIND_RECEIVE, sn, code, cfg.start_symbol, cfg.end_symbol, 1'b1));
            end
            else if (pick < 87)
                offer(make_item(KIND_STOP, sn, 16'($urandom), fb, lb, src));
            else if (pick < 96)
            begin
                fb  = cfg.start_symbol;
                lb  = cfg.end_symbol;
                src = 1'b1;
                case ($urandom_range(2, 0))
                    0:       fb = fb ^ 8'($urandom_range(255, 1));
                    1:       lb = lb ^ 8'($urandom_range(255, 1));
                    default: src = 1'b0;
                endcase
                offer(make_item(KIND_RECEIVE, sn, 16'($urandom), fb, lb, src));
            end
            else
            begin
                k = $urandom_range(7, 0);
                if (k > KIND_STOP)
                    done_items--;
                offer(make_item(3'(k), 16'($urandom), 16'($urandom), fb, lb, src));
            end
        end
    endtask

    initial
    begin : result_sink
        int gap;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            gap = draw_gap();
            if (gap > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (res_if.valid !== 1'b1)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        cfg_t c;
        rst_n                = 1'b0;
        evt_if.valid         = 1'b0;
        evt_if.kind          = KIND_APPEND;
        evt_if.serial_number = 16'h0000;
        evt_if.cmd_code      = 16'h0000;
        evt_if.first_byte    = 8'h00;
        evt_if.final_byte    = 8'h00;
        evt_if.source_ok     = 1'b0;
        write_enable         = 1'b0;
        write_index          = REG_MAX_TIMEOUTS;
        write_data           = 16'h0000;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0: c = '{max_timeouts: 8'd3, heartbeat_code: 16'h0000, notify_code: 16'h0000,
                         cmd_min: 16'h0000, cmd_max: 16'hFFFF,
                         start_symbol: 8'h00, end_symbol: 8'h00};
                1: c = '{max_timeouts: 8'd0, heartbeat_code: 16'hFFFF, notify_code: 16'h8000,
                         cmd_min: 16'h0100, cmd_max: 16'hFEFF,
                         start_symbol: 8'hFF, end_symbol: 8'hFF};
                2: c = '{max_timeouts: 8'd1, heartbeat_code: 16'($urandom),
                         notify_code: 16'($urandom),
                         cmd_min: 16'hFFFF, cmd_max: 16'h0000,
                         start_symbol: 8'hA5, end_symbol: 8'h5A};
                3: c = '{max_timeouts: 8'd2, heartbeat_code: 16'($urandom),
                         notify_code: 16'($urandom),
                         cmd_min: 16'($urandom_range(16'h7FFF, 0)),
                         cmd_max: 16'($urandom_range(16'hFFFF, 16'h8000)),
                         start_symbol: 8'($urandom), end_symbol: 8'($urandom)};
                4: c = '{max_timeouts: 8'd255, heartbeat_code: 16'h0000, notify_code: 16'hFFFF,
                         cmd_min: 16'h0000, cmd_max: 16'h0000,
                         start_symbol: 8'h00, end_symbol: 8'hFF};
                default:
                   c = '{max_timeouts: 8'($urandom_range(8, 4)), heartbeat_code: 16'($urandom),
                         notify_code: 16'($urandom),
                         cmd_min: 16'h7FFF, cmd_max: 16'h8000,
                         start_symbol: 8'($urandom), end_symbol: 8'($urandom)};
            endcase
            program_regs(c);
            quiet = (p == 1);

            if (p == 0)
            begin
                // heartbeat code goes out at once
                offer(make_item(KIND_APPEND, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0));
                // tick with timer idle, start on empty table
                offer(make_item(KIND_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
                offer(make_item(KIND_START, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0));
                offer(make_item(KIND_APPEND, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
                offer(make_item(KIND_APPEND, 16'h0000, 16'h0001, 8'h00, 8'h00, 1'b0));
                offer(make_item(KIND_START, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0));
                offer(make_item(KIND_APPEND, 16'h1234, 16'hEDCB, 8'h00, 8'h00, 1'b0));
                // armed start only sends fresh entries
                offer(make_item(KIND_START, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0));
                // repeated serial clears its count
                offer(make_item(KIND_APPEND, 16'hFFFF, 16'h0002, 8'h00, 8'h00, 1'b0));
                repeat (3) offer(make_item(KIND_TICK, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0));
                offer(make_item(KIND_RECEIVE, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b1));
                // frames failing start, end and source checks
                offer(make_item(KIND_RECEIVE, 16'h5555, 16'h0000, 8'hFF, 8'h00, 1'b1));
                offer(make_item(KIND_RECEIVE, 16'h5555, 16'h0000, 8'h00, 8'hFF, 1'b1));
                offer(make_item(KIND_RECEIVE, 16'h5555, 16'h0000, 8'h00, 8'h00, 1'b0));
                // untracked serial is still delivered
                offer(make_item(KIND_RECEIVE, 16'hABCD, 16'h8000, 8'h00, 8'h00, 1'b1));
                offer(make_item(KIND_APPEND, 16'h00FF, 16'h00FF, 8'h00, 8'h00, 1'b0));
                offer(make_item(KIND_STOP, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
                offer(make_item(KIND_TICK, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0));
                offer(make_item(KIND_START, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0));
                offer(make_item(3'd5, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
                offer(make_item(3'd6, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
                offer(make_item(3'd7, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
            end

            random_traffic(PHASE_ITEMS, (p == 3) ? 20 : -1, (p == 2) ? 30 : -1);
        end

        settle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
